### src/gpe_pkg.sv
// types and constants shared by the gpio port blocks
package gpe_pkg;

  localparam int FIELD_W    = 8;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION  = 3'd0,
    REG_DIG_ENABLE = 3'd1,
    REG_INT_SENSE  = 3'd2,
    REG_BOTH_EDGES = 3'd3,
    REG_INT_EVENT  = 3'd4,
    REG_INT_MASK   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0] direction;
    logic [FIELD_W-1:0] digital_enable;
    logic [FIELD_W-1:0] interrupt_sense;
    logic [FIELD_W-1:0] both_edges;
    logic [FIELD_W-1:0] interrupt_event;
    logic [FIELD_W-1:0] interrupt_mask;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] output_latch;
    logic [FIELD_W-1:0] previous_sample;
    logic [FIELD_W-1:0] edge_status;
  } port_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] pin_levels;
    logic [FIELD_W-1:0] write_value;
    logic [FIELD_W-1:0] write_mask;
  } item_t;

  typedef struct packed {
    logic               irq;
    logic [FIELD_W-1:0] masked_status;
    logic [FIELD_W-1:0] raw_status;
    logic [FIELD_W-1:0] drive_enable;
    logic [FIELD_W-1:0] drive_value;
    logic [FIELD_W-1:0] read_data;
  } result_t;

endpackage

### src/gpe_eval.sv
// combinational evaluation of one word: next port state and result fields
module gpe_eval #(
  parameter int PIN_COUNT = 8
) (
  input  gpe_pkg::cfg_t        cfg,
  input  gpe_pkg::port_state_t cur,
  input  gpe_pkg::item_t       item,
  output gpe_pkg::port_state_t nxt,
  output gpe_pkg::result_t     res
);

  localparam int PINS = (PIN_COUNT < gpe_pkg::FIELD_W) ? PIN_COUNT : gpe_pkg::FIELD_W;
  localparam logic [gpe_pkg::FIELD_W:0] ONE = {{gpe_pkg::FIELD_W{1'b0}}, 1'b1};
  localparam logic [gpe_pkg::FIELD_W-1:0] PIN_MASK =
    gpe_pkg::FIELD_W'((ONE << PINS) - ONE);

  logic [gpe_pkg::FIELD_W-1:0] dir, de, sense, both, ev, imask;
  logic [gpe_pkg::FIELD_W-1:0] pads, wval, wmsk;
  logic [gpe_pkg::FIELD_W-1:0] sample, rising, falling, hits, level, enabled_out;
  logic [gpe_pkg::FIELD_W-1:0] latch, edges, read, raw;

  always_comb begin
    dir   = cfg.direction & PIN_MASK;
    de    = cfg.digital_enable & PIN_MASK;
    sense = cfg.interrupt_sense & PIN_MASK;
    both  = cfg.both_edges & PIN_MASK;
    ev    = cfg.interrupt_event & PIN_MASK;
    imask = cfg.interrupt_mask & PIN_MASK;
    pads  = item.pin_levels & PIN_MASK;
    wval  = item.write_value & PIN_MASK;
    wmsk  = item.write_mask & PIN_MASK;

    // disabled pins sample as zero, so enabling a high pad looks like a rising edge
    sample  = pads & de;
    rising  = sample & ~cur.previous_sample & PIN_MASK;
    falling = ~sample & cur.previous_sample & PIN_MASK;
    hits    = ~sense & PIN_MASK &
              ((both & (rising | falling)) |
               (~both & ev & rising) |
               (~both & ~ev & falling));
    level       = sense & ~(sample ^ ev) & PIN_MASK;
    enabled_out = dir & de;

    latch = cur.output_latch;
    edges = cur.edge_status;
    read  = '0;
    case (item.kind)
      gpe_pkg::KIND_WRITE: latch = ((latch & ~wmsk) | (wval & wmsk)) & PIN_MASK;
      gpe_pkg::KIND_READ:  read  = ((latch & dir) | (sample & ~dir)) & de;
      gpe_pkg::KIND_CLEAR: edges = edges & ~wval;
      default: ;
    endcase
    // a fresh edge wins over a clear of the same bit
    edges = (edges | hits) & PIN_MASK;
    raw   = edges | level;

    nxt.output_latch    = latch;
    nxt.previous_sample = sample;
    nxt.edge_status     = edges;

    res.read_data     = read;
    res.drive_value   = latch & enabled_out;
    res.drive_enable  = enabled_out;
    res.raw_status    = raw;
    res.masked_status = raw & imask;
    res.irq           = |(raw & imask);
  end

endmodule

### src/gpio_port_edge_level_interrupt.sv
// top level of the gpio port with edge and level interrupts
//
// Input stream: in_tvalid/in_tready, in_tuser carries the word kind (sample,
// data write, data read, interrupt clear) and in_tdata the pad levels,
// write value and write mask. Every word samples the pads, then performs
// its access. Result stream: one word per input word with read data, drive
// value and enable, raw and masked status and the irq bit.
// Configuration: cfg_valid/cfg_ready with a register index and 8-bit data;
// cfg_ready is always high, unknown indexes are dropped. Write only while idle.
// From input accept to result valid a word passes an input register, then
// the evaluation logic into the result register, with the port state
// updated as the word moves over. Throughput is one word per clock while
// the receiver takes results, set by that single evaluation stage.
// A stalled receiver holds the result register; the input register still
// takes one more word, after which in_tready drops until the result is taken.
// Synchronous active-low reset clears the configuration, output latch, last
// sample and edge status, and empties both registers.
module gpio_port_edge_level_interrupt #(
  parameter int PIN_COUNT = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpe_pkg::FIELD_W-1:0]      cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [23:16] write_mask, [15:8] write_value, [7:0] pin_levels
  input  logic [gpe_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [gpe_pkg::KIND_W-1:0]       in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [47:41] zero, [40] irq, [39:32] masked_status, [31:24] raw_status,
  // [23:16] drive_enable, [15:8] drive_value, [7:0] read_data
  output logic [gpe_pkg::OUT_DATA_W-1:0]   out_tdata
);

  gpe_pkg::cfg_t        cfg_r, cfg_nxt;
  gpe_pkg::port_state_t state_r, state_nxt;
  gpe_pkg::item_t       item_r, item_nxt;
  gpe_pkg::result_t     res_r, res_nxt;
  logic                 in_valid_r, in_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  gpe_eval #(.PIN_COUNT(PIN_COUNT)) u_eval (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (gpe_pkg::reg_idx_t'(cfg_index))
        gpe_pkg::REG_DIRECTION:  cfg_nxt.direction       = cfg_data;
        gpe_pkg::REG_DIG_ENABLE: cfg_nxt.digital_enable  = cfg_data;
        gpe_pkg::REG_INT_SENSE:  cfg_nxt.interrupt_sense = cfg_data;
        gpe_pkg::REG_BOTH_EDGES: cfg_nxt.both_edges      = cfg_data;
        gpe_pkg::REG_INT_EVENT:  cfg_nxt.interrupt_event = cfg_data;
        gpe_pkg::REG_INT_MASK:   cfg_nxt.interrupt_mask  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item_nxt.kind        = gpe_pkg::kind_t'(in_tuser);
    item_nxt.pin_levels  = in_tdata[7:0];
    item_nxt.write_value = in_tdata[15:8];
    item_nxt.write_mask  = in_tdata[23:16];
    in_valid_nxt  = (in_valid_r && !advance) || (in_tvalid && in_tready);
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      state_r     <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.irq, res_r.masked_status, res_r.raw_status,
                       res_r.drive_enable, res_r.drive_value, res_r.read_data};

  // masked status never shows a bit that raw status lacks
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[39:32] & ~out_tdata[31:24]) == 8'd0))
    else $error("masked status outside raw status");

  // a pin only drives high when it is driven at all
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[15:8] & ~out_tdata[23:16]) == 8'd0))
    else $error("drive value outside drive enable");

  // with the result slot free the block must keep taking words
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // reset empties the pipeline
  assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !in_valid_r))
    else $error("pipeline not empty after reset");

endmodule

### tb/gpe_checker.sv
`timescale 1ns / 100ps
// checker that predicts the gpio port result words and compares them as they leave
module gpe_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpe_pkg::FIELD_W-1:0]    cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [gpe_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [gpe_pkg::KIND_W-1:0]     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [gpe_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             pending
);

  localparam int SHOW_LIMIT = 200;

  gpe_pkg::cfg_t        port_cfg;
  gpe_pkg::port_state_t port_st;
  gpe_pkg::result_t     report_q[$];
  int                   shown;

  // advances the port state by one word and returns the report it produces
  function automatic gpe_pkg::result_t next_port_report(gpe_pkg::item_t w);
    logic [gpe_pkg::FIELD_W-1:0] samp;
    logic [gpe_pkg::FIELD_W-1:0] rise;
    logic [gpe_pkg::FIELD_W-1:0] fall;
    logic [gpe_pkg::FIELD_W-1:0] hits;
    logic [gpe_pkg::FIELD_W-1:0] lvl;
    logic [gpe_pkg::FIELD_W-1:0] en_out;
    gpe_pkg::result_t r;
    samp   = w.pin_levels & port_cfg.digital_enable;
    rise   = samp & ~port_st.previous_sample;
    fall   = ~samp & port_st.previous_sample;
    hits   = ~port_cfg.interrupt_sense &
             ((port_cfg.both_edges & (rise | fall)) |
              (~port_cfg.both_edges & port_cfg.interrupt_event & rise) |
              (~port_cfg.both_edges & ~port_cfg.interrupt_event & fall));
    lvl    = port_cfg.interrupt_sense & ~(samp ^ port_cfg.interrupt_event);
    en_out = port_cfg.direction & port_cfg.digital_enable;
    r      = '0;
    case (w.kind)
      gpe_pkg::KIND_WRITE:
        port_st.output_latch = (port_st.output_latch & ~w.write_mask) |
                               (w.write_value & w.write_mask);
      gpe_pkg::KIND_READ:
        r.read_data = ((port_st.output_latch & port_cfg.direction) |
                       (samp & ~port_cfg.direction)) & port_cfg.digital_enable;
      gpe_pkg::KIND_CLEAR:
        port_st.edge_status = port_st.edge_status & ~w.write_value;
      default: ;
    endcase
    // a fresh edge lands after the clear, so it survives
    port_st.edge_status     = port_st.edge_status | hits;
    port_st.previous_sample = samp;
    r.drive_enable  = en_out;
    r.drive_value   = port_st.output_latch & en_out;
    r.raw_status    = port_st.edge_status | lvl;
    r.masked_status = r.raw_status & port_cfg.interrupt_mask;
    r.irq           = |r.masked_status;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [gpe_pkg::FIELD_W-1:0] want,
                             input logic [gpe_pkg::FIELD_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("%0t ns: %s expected %02h got %02h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    gpe_pkg::result_t got;
    gpe_pkg::result_t want;
    gpe_pkg::item_t   w;
    if (!rst_n) begin
      port_cfg = '0;
      port_st  = '0;
      report_q.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = gpe_pkg::result_t'(out_tdata[40:0]);
        if (report_q.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t ns: result word expected none got %011h", $time, out_tdata);
          end
        end else begin
          want = report_q.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("drive_value", want.drive_value, got.drive_value);
          check_field("drive_enable", want.drive_enable, got.drive_enable);
          check_field("raw_status", want.raw_status, got.raw_status);
          check_field("masked_status", want.masked_status, got.masked_status);
          check_field("irq", {7'd0, want.irq}, {7'd0, got.irq});
        end
        check_field("tdata fill", 8'h00, {1'b0, out_tdata[47:41]});
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gpe_pkg::REG_DIRECTION:  port_cfg.direction       = cfg_data;
          gpe_pkg::REG_DIG_ENABLE: port_cfg.digital_enable  = cfg_data;
          gpe_pkg::REG_INT_SENSE:  port_cfg.interrupt_sense = cfg_data;
          gpe_pkg::REG_BOTH_EDGES: port_cfg.both_edges      = cfg_data;
          gpe_pkg::REG_INT_EVENT:  port_cfg.interrupt_event = cfg_data;
          gpe_pkg::REG_INT_MASK:   port_cfg.interrupt_mask  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        w.kind        = gpe_pkg::kind_t'(in_tuser);
        w.pin_levels  = in_tdata[7:0];
        w.write_value = in_tdata[15:8];
        w.write_mask  = in_tdata[23:16];
        report_q.push_back(next_port_report(w));
      end
      pending <= report_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// top of the gpio port testbench: clock, reset, stimulus, result sink and verdict
module testbench;

  // indexes past the last register, writes there must be dropped
  localparam logic [gpe_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [gpe_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 140;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [gpe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gpe_pkg::FIELD_W-1:0]    cfg_data;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [gpe_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [gpe_pkg::KIND_W-1:0]     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [gpe_pkg::OUT_DATA_W-1:0] out_tdata;
  int                             fail_count;
  int                             pending;
  bit                             steady;

  gpio_port_edge_level_interrupt dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gpe_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [gpe_pkg::FIELD_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // valid stays high after the word is taken; the next call either moves on or drops it
  task automatic send_word(input gpe_pkg::kind_t kind,
                           input logic [gpe_pkg::FIELD_W-1:0] pads,
                           input logic [gpe_pkg::FIELD_W-1:0] wval,
                           input logic [gpe_pkg::FIELD_W-1:0] wmsk);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {wmsk, wval, pads};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gpe_pkg::FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [gpe_pkg::FIELD_W-1:0] dir,
                             input logic [gpe_pkg::FIELD_W-1:0] den,
                             input logic [gpe_pkg::FIELD_W-1:0] sense,
                             input logic [gpe_pkg::FIELD_W-1:0] both,
                             input logic [gpe_pkg::FIELD_W-1:0] evt,
                             input logic [gpe_pkg::FIELD_W-1:0] msk);
    write_reg(IDX_SPARE_LO, pick_byte());
    write_reg(gpe_pkg::REG_DIRECTION, dir);
    write_reg(gpe_pkg::REG_DIG_ENABLE, den);
    write_reg(gpe_pkg::REG_INT_SENSE, sense);
    write_reg(IDX_SPARE_HI, pick_byte());
    write_reg(gpe_pkg::REG_BOTH_EDGES, both);
    write_reg(gpe_pkg::REG_INT_EVENT, evt);
    write_reg(gpe_pkg::REG_INT_MASK, msk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: ready runs broken by stalls, now and then a long run with no stall
  initial begin : result_sink
    int run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      run = idle_len();
      if (run > 0) begin
        out_tready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [gpe_pkg::FIELD_W-1:0] pads;
    int r;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    steady    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: everything disabled, a write still lands in the latch
    send_word(gpe_pkg::KIND_SAMPLE, 8'hFF, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_WRITE, 8'hFF, 8'h5A, 8'hFF);
    send_word(gpe_pkg::KIND_READ, 8'hFF, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_CLEAR, 8'h00, 8'hFF, 8'hFF);
    settle();

    // enabling the buffers turns high pads into rising edges
    load_config(8'hF0, 8'hFF, 8'h00, 8'h33, 8'h55, 8'hFF);
    send_word(gpe_pkg::KIND_SAMPLE, 8'hFF, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_CLEAR, 8'h00, 8'hFF, 8'h00);
    send_word(gpe_pkg::KIND_READ, 8'hA5, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_WRITE, 8'hA5, 8'h00, 8'hF0);
    send_word(gpe_pkg::KIND_SAMPLE, 8'h00, 8'hFF, 8'hFF);
    send_word(gpe_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 8'h00);
    send_word(gpe_pkg::KIND_SAMPLE, 8'hFF, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_WRITE, 8'h00, 8'hFF, 8'h0F);
    send_word(gpe_pkg::KIND_READ, 8'h00, 8'h00, 8'h00);
    settle();

    // switch to level sense with edges still latched, then try clearing level bits
    load_config(8'h00, 8'h0F, 8'hFF, 8'h00, 8'h0F, 8'hF0);
    send_word(gpe_pkg::KIND_SAMPLE, 8'h0F, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_CLEAR, 8'h0F, 8'h0F, 8'h00);
    send_word(gpe_pkg::KIND_READ, 8'hFF, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_SAMPLE, 8'h00, 8'h00, 8'h00);
    send_word(gpe_pkg::KIND_CLEAR, 8'h00, 8'hFF, 8'hFF);
    send_word(gpe_pkg::KIND_WRITE, 8'hFF, 8'hFF, 8'hFF);

    pads = 8'h00;
    for (int k = 0; k < PHASES; k++) begin
      settle();
      steady = (k % 4 == 3);
      if (k == 0)
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else if (k == 1)
        load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      else
        load_config(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                    pick_byte());
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 79) == 0) settle();
        // pads move one pin at a time in four words of ten so edges and clears interleave
        r = $urandom_range(0, 9);
        if (r < 4)
          pads = 8'($urandom_range(0, 255));
        else if (r < 8)
          pads = pads ^ (8'd1 << $urandom_range(0, 7));
        else if (r == 8)
          pads = ~pads;
        send_word(gpe_pkg::kind_t'($urandom_range(0, 3)), pads, pick_byte(), pick_byte());
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
src/gpe_pkg.sv
src/gpe_eval.sv
src/gpio_port_edge_level_interrupt.sv
tb/gpe_checker.sv
tb/testbench.sv
